>>> src/azc_pkg.sv
// Shared types and constants for the axis zone crossing detector.
`timescale 1ns / 1ps

package azc_pkg;

  // Largest number of thresholds that the block holds.
  localparam int unsigned MaxPoints = 7;

  localparam int unsigned SampleW  = 16;
  localparam int unsigned ZoneW    = 3;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 16;

  typedef logic signed [SampleW-1:0] sample_t;
  typedef logic [ZoneW-1:0]          zone_t;

  // Configuration register indexes.
  typedef enum logic [CfgIdxW-1:0] {
    REG_NUM_POINTS  = 3'd0,
    REG_THRESHOLD_0 = 3'd1,
    REG_THRESHOLD_1 = 3'd2,
    REG_THRESHOLD_2 = 3'd3,
    REG_THRESHOLD_3 = 3'd4,
    REG_THRESHOLD_4 = 3'd5,
    REG_THRESHOLD_5 = 3'd6,
    REG_THRESHOLD_6 = 3'd7
  } reg_idx_e;

  // Configuration as seen by the evaluation logic.
  typedef struct packed {
    zone_t                              n_active;
    logic [MaxPoints-1:0][SampleW-1:0]  thr;
  } cfg_t;

  // Outcome of evaluating one sample against the held zone.
  typedef struct packed {
    logic  crossed;
    logic  up;
    zone_t zone;
  } eval_t;

endpackage

>>> src/axis_zone_crossing_detector.sv
// Top level of the axis zone crossing detector.
//
//   Channel   Handshake                                  Payload
//   sample    axis_sample_valid_i / axis_sample_stall_o  axis_sample_i
//   result    result_valid_o / result_stall_i            crossed_o, upward_o, zone_now_o
//   config    cfg_we_i                                   cfg_index_i, cfg_wdata_i
//
// One transaction per cycle is sustained while results are not stalled; a
// sample is taken into the input register, which feeds the result register.
// The zone and direction registers close a loop through the comparator
// bank, which sets the rate at one sample per clock.
// Reset gives zone 0, direction up, one threshold point and all thresholds 0.
// A stalled result holds the pipeline; the sample side stalls only when both
// the input register and the result register are full and the result is stalled.
`timescale 1ns / 1ps

module axis_zone_crossing_detector
  import azc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  input  logic                axis_sample_valid_i,
  output logic                axis_sample_stall_o,
  input  sample_t             axis_sample_i,
  output logic                result_valid_o,
  input  logic                result_stall_i,
  output logic                crossed_o,
  output logic                upward_o,
  output zone_t               zone_now_o
);

  cfg_t    cfg;
  eval_t   eval;

  logic    in_valid_q, in_valid_d;
  sample_t sample_q;
  logic    out_valid_q, out_valid_d;
  logic    crossed_q;
  zone_t   zone_q, zone_d;
  logic    dir_q, dir_d;

  logic    out_ready;
  logic    s1_fire;
  logic    in_ready;
  logic    in_take;

  azc_cfg_regs u_cfg_regs (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  azc_zone_eval u_zone_eval (
    .sample_i (sample_q),
    .cfg_i    (cfg),
    .zone_i   (zone_q),
    .eval_o   (eval)
  );

  // Pipeline flow control.
  assign out_ready           = !out_valid_q || !result_stall_i;
  assign s1_fire             = in_valid_q && out_ready;
  assign in_ready            = !in_valid_q || s1_fire;
  assign in_take             = axis_sample_valid_i && in_ready;
  assign axis_sample_stall_o = !in_ready;

  always_comb begin
    in_valid_d  = in_take ? 1'b1 : (s1_fire ? 1'b0 : in_valid_q);
    out_valid_d = s1_fire ? 1'b1 : (out_ready ? 1'b0 : out_valid_q);
    zone_d      = s1_fire ? eval.zone : zone_q;
    dir_d       = (s1_fire && eval.crossed) ? eval.up : dir_q;
  end

  // Control, zone state and direction state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      zone_q      <= '0;
      dir_q       <= 1'b1;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      zone_q      <= zone_d;
      dir_q       <= dir_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_take) begin
      sample_q <= axis_sample_i;
    end
    if (s1_fire) begin
      crossed_q <= eval.crossed;
    end
  end

  assign result_valid_o = out_valid_q;
  assign crossed_o      = crossed_q;
  assign upward_o       = dir_q;
  assign zone_now_o     = zone_q;

  // The sample side stalls only while the input register holds a transaction.
  a_stall_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    axis_sample_stall_o |-> in_valid_q)
    else $error("sample stall without a held transaction");

  // An evaluated sample always lands in the result register.
  a_fire_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_fire |=> result_valid_o)
    else $error("evaluated sample produced no result");

  // The direction only changes when a crossing is evaluated.
  a_dir_on_cross: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(s1_fire && eval.crossed) |=> $stable(dir_q))
    else $error("direction changed without a crossing");

  // The zone state only moves when a sample is evaluated.
  a_zone_on_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s1_fire |=> $stable(zone_q))
    else $error("zone changed without an evaluated sample");

endmodule

>>> src/azc_cfg_regs.sv
// Configuration register file: point count and zone thresholds.
`timescale 1ns / 1ps

module azc_cfg_regs
  import azc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic [CfgIdxW-1:0]  cfg_index_i,
  input  logic [CfgDataW-1:0] cfg_wdata_i,
  output cfg_t                cfg_o
);

  zone_t                             num_points_q;
  logic [MaxPoints-1:0][SampleW-1:0] thr_q;
  logic [CfgIdxW-1:0]                thr_idx;

  // Threshold k lives at register index k + 1.
  assign thr_idx = cfg_index_i - CfgIdxW'(1);

  // Register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_points_q <= ZoneW'(1);
      thr_q        <= '0;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_index_i))
        REG_NUM_POINTS: begin
          num_points_q <= cfg_wdata_i[ZoneW-1:0];
        end
        default: begin
          thr_q[thr_idx] <= cfg_wdata_i[SampleW-1:0];
        end
      endcase
    end
  end

  // Clamp the point count into the supported range.
  always_comb begin
    cfg_o.thr = thr_q;
    if (num_points_q == '0) begin
      cfg_o.n_active = ZoneW'(1);
    end else if (num_points_q > ZoneW'(MaxPoints)) begin
      cfg_o.n_active = ZoneW'(MaxPoints);
    end else begin
      cfg_o.n_active = num_points_q;
    end
  end

endmodule

>>> src/azc_zone_eval.sv
// Comparator bank, crossing test and zone search for one sample.
`timescale 1ns / 1ps

module azc_zone_eval
  import azc_pkg::*;
(
  input  sample_t sample_i,
  input  cfg_t    cfg_i,
  input  zone_t   zone_i,
  output eval_t   eval_o
);

  logic [MaxPoints-1:0] lt;
  logic                 le_first;
  zone_t                n;
  zone_t                n_m1;
  zone_t                z_sat;
  logic                 fire_up;
  logic                 fire_down;
  zone_t                zone_found;

  // One less-than comparator per threshold, plus a less-or-equal test on the first.
  always_comb begin
    for (int i = 0; i < MaxPoints; i++) begin
      lt[i] = sample_i < $signed(cfg_i.thr[i]);
    end
    le_first = sample_i <= $signed(cfg_i.thr[0]);
  end

  assign n    = cfg_i.n_active;
  assign n_m1 = n - ZoneW'(1);

  // A held zone above the top is saturated before it is judged.
  assign z_sat = (zone_i > n) ? n : zone_i;

  // Crossing test against the boundaries of the held zone.
  always_comb begin
    fire_up   = 1'b0;
    fire_down = 1'b0;
    if (z_sat == '0) begin
      fire_up = !lt[0];
    end else if (z_sat == n) begin
      fire_down = lt[n_m1];
    end else begin
      fire_up   = !lt[z_sat];
      fire_down = !lt[z_sat] ? 1'b0 : lt[z_sat - ZoneW'(1)];
    end
  end

  // Zone search: clip at both ends, otherwise bisect on the comparator bits.
  // Three halving steps cover seven thresholds; a step on an adjacent pair
  // leaves the bounds unchanged.
  always_comb begin
    logic [ZoneW-1:0] lo;
    logic [ZoneW-1:0] hi;
    logic [ZoneW:0]   sum;
    logic [ZoneW-1:0] mid;
    lo  = '0;
    hi  = n_m1;
    sum = '0;
    mid = '0;
    for (int s = 0; s < 3; s++) begin
      sum = {1'b0, lo} + {1'b0, hi};
      mid = sum[ZoneW:1];
      if (lt[mid]) begin
        hi = mid;
      end else begin
        lo = mid;
      end
    end
    if (le_first) begin
      zone_found = '0;
    end else if (!lt[n_m1]) begin
      zone_found = n;
    end else begin
      zone_found = hi;
    end
  end

  assign eval_o.crossed = fire_up | fire_down;
  assign eval_o.up      = fire_up;
  assign eval_o.zone    = (fire_up | fire_down) ? zone_found : z_sat;

endmodule

>>> sim/tb.sv
// Self-checking testbench for the axis zone crossing detector.
`timescale 1ns / 1ps

module tb;
  import azc_pkg::*;

  // Cycles that the receiver holds off in one stretch to fill the block.
  localparam int unsigned HoldCycles = 300;
  // Cycles to let pass after the last result before touching registers.
  localparam int unsigned SettleCycles = 4;
  localparam int unsigned BatchCount = 16;
  localparam int unsigned BatchItems = 100;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0]  cfg_index_i = '0;
  logic [CfgDataW-1:0] cfg_wdata_i = '0;
  logic                axis_sample_valid_i = 1'b0;
  logic                axis_sample_stall_o;
  sample_t             axis_sample_i = '0;
  logic                result_valid_o;
  logic                result_stall_i = 1'b0;
  logic                crossed_o;
  logic                upward_o;
  zone_t               zone_now_o;

  axis_zone_crossing_detector dut (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .cfg_we_i            (cfg_we_i),
    .cfg_index_i         (cfg_index_i),
    .cfg_wdata_i         (cfg_wdata_i),
    .axis_sample_valid_i (axis_sample_valid_i),
    .axis_sample_stall_o (axis_sample_stall_o),
    .axis_sample_i       (axis_sample_i),
    .result_valid_o      (result_valid_o),
    .result_stall_i      (result_stall_i),
    .crossed_o           (crossed_o),
    .upward_o            (upward_o),
    .zone_now_o          (zone_now_o)
  );

  // Clock with a 4 ns period.
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Samples waiting to be offered and the zone reports they will cause.
  sample_t samples_to_send[$];
  eval_t   zone_reports_due[$];

  // Shadow copy of the register file and of the tracked zone state.
  logic [2:0] cfg_points = 3'd1;
  sample_t    cfg_thr [MaxPoints] = '{default: '0};
  zone_t      held_zone = '0;
  logic       held_up = 1'b1;

  // Threshold set that the next register setting will load.
  sample_t plan_thr [MaxPoints];

  // Idling controls, set per phase by the stimulus block.
  int unsigned send_gap_pct = 0;
  int unsigned stall_pct = 0;
  logic        hold_go = 1'b0;
  int unsigned hold_left = 0;

  int unsigned errors = 0;
  int unsigned samples_taken = 0;
  int unsigned results_checked = 0;
  int unsigned ups_seen = 0;
  int unsigned downs_seen = 0;
  int unsigned settings_applied = 0;
  int unsigned held_off_cycles = 0;

  // Prints one line per mismatch and counts it.
  task automatic log_mismatch(input string what);
    errors++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  // Thresholds in use; a zero count behaves as one.
  function automatic int unsigned points_in_use();
    return (cfg_points == 3'd0) ? 1 : int'(cfg_points);
  endfunction

  // Zone that a sample falls in, searching the thresholds by halving.
  function automatic zone_t zone_for(input sample_t v, input int unsigned n);
    int unsigned lo;
    int unsigned hi;
    int unsigned mid;
    if (v <= cfg_thr[0]) return '0;
    if (v >= cfg_thr[n-1]) return zone_t'(n);
    lo = 0;
    hi = n - 1;
    while (hi != lo + 1) begin
      mid = (lo + hi) / 2;
      if (v < cfg_thr[mid]) hi = mid;
      else lo = mid;
    end
    return zone_t'(hi);
  endfunction

  // Advances the tracked zone by one sample and queues the report it causes.
  task automatic track_zone(input sample_t v);
    int unsigned n;
    zone_t       z;
    logic        up_hit;
    logic        down_hit;
    eval_t       report;
    n = points_in_use();
    // A zone left above the top by a lowered count saturates first.
    if (held_zone > n) held_zone = zone_t'(n);
    z = held_zone;
    up_hit = 1'b0;
    down_hit = 1'b0;
    if (z == 0) begin
      up_hit = (v >= cfg_thr[0]);
    end else if (z == n) begin
      down_hit = (v < cfg_thr[n-1]);
    end else if (v >= cfg_thr[z]) begin
      up_hit = 1'b1;
    end else if (v < cfg_thr[z-1]) begin
      down_hit = 1'b1;
    end
    if (up_hit || down_hit) begin
      held_up = up_hit;
      held_zone = zone_for(v, n);
    end
    report.crossed = up_hit | down_hit;
    report.up = held_up;
    report.zone = held_zone;
    zone_reports_due.push_back(report);
  endtask

  // Sample near an active threshold, at an extreme, at 0 or -1, or anywhere.
  function automatic sample_t pick_sample();
    int v;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 50) begin
      v = int'(cfg_thr[$urandom_range(0, points_in_use() - 1)]) + $urandom_range(0, 4) - 2;
      if (v > 32767) v = 32767;
      if (v < -32768) v = -32768;
    end else if (roll < 62) begin
      case ($urandom_range(0, 3))
        0: v = -32768;
        1: v = 32767;
        2: v = 0;
        default: v = -1;
      endcase
    end else begin
      v = int'(sample_t'($urandom));
    end
    return sample_t'(v);
  endfunction

  // Sample driver: offers queued samples, idling at random between them.
  always @(posedge clk_i or negedge rst_ni) begin
    logic load_next;
    if (!rst_ni) begin
      axis_sample_valid_i <= 1'b0;
      axis_sample_i <= '0;
    end else begin
      if (axis_sample_valid_i && !axis_sample_stall_o) begin
        track_zone(axis_sample_i);
        samples_taken++;
      end
      if (axis_sample_valid_i && axis_sample_stall_o) begin
        held_off_cycles++;
      end else begin
        load_next = (samples_to_send.size() != 0) &&
                    ($urandom_range(0, 99) >= send_gap_pct);
        if (load_next) begin
          axis_sample_valid_i <= 1'b1;
          axis_sample_i <= samples_to_send.pop_front();
        end else begin
          axis_sample_valid_i <= 1'b0;
        end
      end
    end
  end

  // Result receiver: random stalls plus one long hold-off on request.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      result_stall_i <= 1'b0;
      hold_left <= 0;
    end else begin
      if (hold_go) hold_left <= HoldCycles;
      else if (hold_left != 0) hold_left <= hold_left - 1;
      result_stall_i <= hold_go || (hold_left > 1) ||
                        ($urandom_range(0, 99) < stall_pct);
    end
  end

  // Result monitor: compares each transaction with the oldest expected report.
  always @(posedge clk_i) begin
    eval_t want;
    if (rst_ni && result_valid_o && !result_stall_i) begin
      if (zone_reports_due.size() == 0) begin
        log_mismatch($sformatf("result with none expected (crossed %0b up %0b zone %0d)",
                               crossed_o, upward_o, zone_now_o));
      end else begin
        want = zone_reports_due.pop_front();
        results_checked++;
        if (crossed_o !== want.crossed)
          log_mismatch($sformatf("crossed %0b, expected %0b", crossed_o, want.crossed));
        if (upward_o !== want.up)
          log_mismatch($sformatf("upward %0b, expected %0b", upward_o, want.up));
        if (zone_now_o !== want.zone)
          log_mismatch($sformatf("zone_now %0d, expected %0d", zone_now_o, want.zone));
        if (want.crossed && want.up) ups_seen++;
        if (want.crossed && !want.up) downs_seen++;
      end
    end
  end

  // Waits until every sample is taken and every report has arrived.
  task automatic drain();
    @(negedge clk_i);
    while (samples_to_send.size() != 0 || axis_sample_valid_i ||
           zone_reports_due.size() != 0)
      @(negedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
  endtask

  // Writes one register and mirrors it into the shadow copy.
  task automatic write_reg(input reg_idx_e idx, input logic [CfgDataW-1:0] data);
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_wdata_i <= data;
    if (idx == REG_NUM_POINTS) cfg_points = data[2:0];
    else cfg_thr[idx - REG_THRESHOLD_0] = sample_t'(data);
  endtask

  // Loads the count word and the planned thresholds into the block.
  task automatic apply_setting(input logic [CfgDataW-1:0] points_word);
    write_reg(REG_NUM_POINTS, points_word);
    for (int i = 0; i < MaxPoints; i++)
      write_reg(reg_idx_e'(REG_THRESHOLD_0 + i), plan_thr[i]);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    settings_applied++;
    @(negedge clk_i);
  endtask

  task automatic queue_sample(input int v);
    samples_to_send.push_back(sample_t'(v));
  endtask

  // Timeout guard.
  initial begin
    #2_000_000;
    $display("== FAIL ==");
    $finish;
  end

  // Stimulus sequence.
  initial begin
    sample_t     swap;
    int unsigned span;
    int          base;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Three ascending thresholds, samples on and around each boundary.
    plan_thr = '{-16384, 0, 16384, 100, 200, 300, 400};
    apply_setting(16'd3);
    queue_sample(-32768);
    queue_sample(-16384);
    queue_sample(-16383);
    queue_sample(0);
    queue_sample(32767);
    queue_sample(16384);
    queue_sample(16383);
    queue_sample(-32768);
    queue_sample(32767);
    drain();

    // Count lowered below the held zone; upper word bits are ignored.
    apply_setting(16'hfff9);
    queue_sample(5);
    queue_sample(-20000);
    drain();

    // A zero count behaves as a single threshold.
    plan_thr = '{32767, -5, -5, -5, -5, -5, -5};
    apply_setting(16'h0008);
    queue_sample(32766);
    queue_sample(32767);
    drain();

    // Unsorted thresholds still give a fixed answer.
    plan_thr = '{3000, -3000, 2000, -2000, 1000, -1000, 0};
    apply_setting(16'd7);
    queue_sample(0);
    queue_sample(5000);
    queue_sample(-5000);
    queue_sample(1500);
    queue_sample(-32768);
    queue_sample(32767);
    drain();

    // Full set of thresholds reaching both ends of the axis.
    plan_thr = '{-32768, -20000, -100, 0, 100, 20000, 32767};
    apply_setting(16'd7);
    queue_sample(-32768);
    queue_sample(32767);
    queue_sample(-32768);
    queue_sample(50);
    queue_sample(-101);
    queue_sample(-1);
    drain();

    // Random phases, each with a fresh register setting.
    for (int b = 0; b < BatchCount; b++) begin
      case (b % 4)
        0: begin send_gap_pct = 0;  stall_pct = 0;  end
        1: begin send_gap_pct = 45; stall_pct = 0;  end
        2: begin send_gap_pct = 0;  stall_pct = 45; end
        default: begin send_gap_pct = 18; stall_pct = 18; end
      endcase

      // Thresholds over the whole axis or packed into a narrow band.
      span = ($urandom_range(0, 1) != 0) ? 65536 : $urandom_range(8, 400);
      base = $urandom_range(0, 65536 - span) - 32768;
      for (int i = 0; i < MaxPoints; i++)
        plan_thr[i] = sample_t'(base + $urandom_range(0, span - 1));
      if ($urandom_range(0, 3) != 0) begin
        for (int i = 0; i < MaxPoints - 1; i++)
          for (int j = 0; j < MaxPoints - 1 - i; j++)
            if (plan_thr[j] > plan_thr[j+1]) begin
              swap = plan_thr[j];
              plan_thr[j] = plan_thr[j+1];
              plan_thr[j+1] = swap;
            end
        if ($urandom_range(0, 4) == 0) begin
          plan_thr[0] = -32768;
          plan_thr[MaxPoints-1] = 32767;
        end
      end
      if (b == 0) apply_setting({13'($urandom_range(0, 8191)), 3'd7});
      else if (b == 1) apply_setting({13'($urandom_range(0, 8191)), 3'd1});
      else apply_setting(16'($urandom));

      for (int k = 0; k < BatchItems; k++)
        samples_to_send.push_back(pick_sample());

      // One long receiver hold-off while the sender keeps offering.
      if (b == 4) begin
        @(posedge clk_i);
        hold_go <= 1'b1;
        @(posedge clk_i);
        hold_go <= 1'b0;
      end
      drain();
    end

    repeat (10) @(posedge clk_i);
    $display("Checked %0d zone reports from %0d samples across %0d register settings.",
             results_checked, samples_taken, settings_applied);
    $display("Saw %0d upward and %0d downward crossings; sample input held off %0d cycles.",
             ups_seen, downs_seen, held_off_cycles);
    if (errors == 0 && zone_reports_due.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> sim.f
src/azc_pkg.sv
src/azc_cfg_regs.sv
src/azc_zone_eval.sv
src/axis_zone_crossing_detector.sv
sim/tb.sv
